FILE: rtl/rme_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared types and constants
// Holds the CORDIC angle table, fixed-point constants and the stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

   localparam int SQRT_STEPS = 15;
   localparam int ATAN_LEN   = 24;

   localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [16:0] PI_Q13      = 17'sd25736;
   localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
   localparam logic signed [15:0] UNIT_Q14    = 16'sd16384;

   localparam logic signed [27:0] ATAN_TAB [0:ATAN_LEN-1] = '{
      28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
      28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
      28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
      28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
      28'sd256,      28'sd128,     28'sd64,      28'sd32,
      28'sd16,       28'sd8,       28'sd4,       28'sd2
   };

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [27:0] z;
      logic               zero;
   } lane_type;

   typedef struct packed {
      logic [29:0]        rem;
      logic [29:0]        res;
      logic signed [15:0] s;
      logic               locked;
      lane_type           pitch;
      lane_type           yaw;
      lane_type           roll;
   } work_type;

endpackage

`default_nettype wire

FILE: rtl/rotation_matrix_to_euler_unit.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles
// Pipelined square root and three parallel CORDIC vectoring lanes.
// ----------------------------------------------------------------------------
// Each request carries seven Q2.14 elements of a rotation matrix. The response
// carries yaw and roll in Q3.13 radians, pitch in Q2.13 radians and a gimbal
// lock flag. Requests may be presented in every cycle; one request is accepted
// per cycle while req_stall is low. On its way to the rsp_ ports a request
// passes one stage for the sine clamp, one for the products, fifteen for the
// square root, one for quadrant pre-rotation, CORDIC_STAGES CORDIC iterations
// and one for rounding into the output register. The user must write the lock
// threshold through the csr_ port only while the block is idle (the block does
// not enforce this); it resets to 1. Synchronous reset empties the pipeline.
// When the receiver raises rsp_stall while a response is held, the whole
// pipeline freezes and req_stall is raised, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [14:0]        csr_lock_epsilon,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_elem_21,
   input  wire logic signed [15:0] req_elem_22,
   input  wire logic signed [15:0] req_elem_20,
   input  wire logic signed [15:0] req_elem_11,
   input  wire logic signed [15:0] req_elem_01,
   input  wire logic signed [15:0] req_elem_00,
   input  wire logic signed [15:0] req_elem_02,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_yaw_angle,
   output logic signed [14:0]      rsp_pitch_angle,
   output logic signed [15:0]      rsp_roll_angle,
   output logic                    rsp_gimbal_locked
);
   import rme_pkg::*;

   localparam int SQ_FIRST = 2;
   localparam int PRE      = SQ_FIRST + SQRT_STEPS;
   localparam int LAST     = PRE + CORDIC_STAGES;

   function automatic lane_type cordic_step(input lane_type a, input int i);
      lane_type           r;
      logic signed [33:0] xs;
      logic signed [33:0] ys;
      r  = a;
      xs = a.x >>> i;
      ys = a.y >>> i;
      if (!a.y[33]) begin
         r.x = a.x + ys;
         r.y = a.y - xs;
         r.z = a.z + ATAN_TAB[i];
      end else begin
         r.x = a.x - ys;
         r.y = a.y + xs;
         r.z = a.z - ATAN_TAB[i];
      end
      return r;
   endfunction

   function automatic lane_type pre_rotate(input lane_type a);
      lane_type r;
      r      = a;
      r.zero = (a.x == '0) && (a.y == '0);
      r.z    = '0;
      if (a.x[33]) begin
         if (!a.y[33]) begin
            r.x = a.y;
            r.y = -a.x;
            r.z = HALF_PI_Q24;
         end else begin
            r.x = -a.y;
            r.y = a.x;
            r.z = -HALF_PI_Q24;
         end
      end
      return r;
   endfunction

   function automatic logic signed [16:0] round_angle(input lane_type a);
      logic signed [27:0] t;
      logic signed [16:0] q;
      t = a.z + 28'sd1024;
      q = 17'(t >>> 11);
      if (a.zero) begin
         q = '0;
      end else if (q > PI_Q13) begin
         q = PI_Q13;
      end else if (q < -PI_Q13) begin
         q = -PI_Q13;
      end
      return q;
   endfunction

   logic        [14:0] eps_ff;
   logic               advance;
   logic signed [16:0] neg_21;
   logic signed [15:0] s_clamp;
   logic        [14:0] s_mag;
   logic               lock_now;
   work_type           entry;
   work_type           work_in [0:LAST];
   work_type           work_ff [0:LAST];
   logic               valid_ff [0:LAST];
   logic signed [16:0] yaw_q;
   logic signed [16:0] roll_q;
   logic signed [16:0] pitch_q;
   logic               rsp_valid_ff;
   logic signed [15:0] yaw_ff;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] roll_ff;
   logic               locked_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= 15'd1;
      end else if (csr_valid) begin
         eps_ff <= csr_lock_epsilon;
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      neg_21 = -{req_elem_21[15], req_elem_21};
      if (neg_21 > 17'sd16384) begin
         s_clamp = UNIT_Q14;
      end else if (neg_21 < -17'sd16384) begin
         s_clamp = -UNIT_Q14;
      end else begin
         s_clamp = 16'(neg_21);
      end
      s_mag    = s_clamp[15] ? 15'(-s_clamp) : 15'(s_clamp);
      lock_now = (15'(UNIT_Q14) - s_mag) <= eps_ff;

      entry        = '0;
      entry.s      = s_clamp;
      entry.locked = lock_now;
      entry.yaw.y  = 34'(req_elem_20);
      entry.yaw.x  = 34'(req_elem_22);
      entry.roll.y = lock_now ? 34'(req_elem_02) : 34'(req_elem_01);
      entry.roll.x = lock_now ? 34'(req_elem_00) : 34'(req_elem_11);
   end

   assign work_in[0] = entry;

   always_comb begin
      logic signed [31:0] sq;
      logic signed [31:0] prod;
      work_in[1] = work_ff[0];
      sq   = work_ff[0].s * work_ff[0].s;
      prod = 16'(work_ff[0].roll.y) * work_ff[0].s;
      work_in[1].rem    = 30'(2 ** 28) - 30'(sq);
      work_in[1].res    = '0;
      work_in[1].yaw.y  = work_ff[0].yaw.y <<< 14;
      work_in[1].yaw.x  = work_ff[0].yaw.x <<< 14;
      work_in[1].roll.y = work_ff[0].locked ? 34'(prod) : (work_ff[0].roll.y <<< 14);
      work_in[1].roll.x = work_ff[0].roll.x <<< 14;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      always_comb begin
         logic [29:0] bit_val;
         logic [29:0] trial;
         bit_val = 30'(1) << (28 - 2 * k);
         trial   = work_ff[SQ_FIRST+k-1].res + bit_val;
         work_in[SQ_FIRST+k] = work_ff[SQ_FIRST+k-1];
         if (work_ff[SQ_FIRST+k-1].rem >= trial) begin
            work_in[SQ_FIRST+k].rem = work_ff[SQ_FIRST+k-1].rem - trial;
            work_in[SQ_FIRST+k].res = (work_ff[SQ_FIRST+k-1].res >> 1) + bit_val;
         end else begin
            work_in[SQ_FIRST+k].res = work_ff[SQ_FIRST+k-1].res >> 1;
         end
      end
   end

   always_comb begin
      work_in[PRE]         = work_ff[PRE-1];
      work_in[PRE].yaw     = pre_rotate(work_ff[PRE-1].yaw);
      work_in[PRE].roll    = pre_rotate(work_ff[PRE-1].roll);
      work_in[PRE].pitch.y = 34'(work_ff[PRE-1].s) <<< 14;
      work_in[PRE].pitch.x = 34'(work_ff[PRE-1].res) <<< 14;
      work_in[PRE].pitch.z = '0;
      work_in[PRE].pitch.zero = 1'b0;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      always_comb begin
         work_in[PRE+1+i]       = work_ff[PRE+i];
         work_in[PRE+1+i].pitch = cordic_step(work_ff[PRE+i].pitch, i);
         work_in[PRE+1+i].yaw   = cordic_step(work_ff[PRE+i].yaw, i);
         work_in[PRE+1+i].roll  = cordic_step(work_ff[PRE+i].roll, i);
      end
   end

   for (genvar j = 0; j <= LAST; j++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= (j == 0) ? req_valid : valid_ff[(j == 0) ? 0 : j - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            work_ff[j] <= work_in[j];
         end
      end
   end

   always_comb begin
      yaw_q   = round_angle(work_ff[LAST].yaw);
      roll_q  = round_angle(work_ff[LAST].roll);
      pitch_q = round_angle(work_ff[LAST].pitch);
      if (pitch_q > HALF_PI_Q13) begin
         pitch_q = HALF_PI_Q13;
      end else if (pitch_q < -HALF_PI_Q13) begin
         pitch_q = -HALF_PI_Q13;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         yaw_ff    <= work_ff[LAST].locked ? 16'sd0 : 16'(yaw_q);
         pitch_ff  <= 15'(pitch_q);
         roll_ff   <= 16'(roll_q);
         locked_ff <= work_ff[LAST].locked;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_gimbal_locked = locked_ff;

endmodule

`default_nettype wire

FILE: sim/tb_rotation_matrix_to_euler_unit.sv
// ----------------------------------------------------------------------------
// Rotation matrix to Euler angles testbench
// Drives matrix requests with random gaps and response stalls, predicts each
// response with a CORDIC angle predictor, and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotation_matrix_to_euler_unit;

   localparam int STAGES = 16;
   localparam int LATENCY = STAGES + 19;

   typedef struct {
      logic signed [15:0] m21, m22, m20, m11, m01, m00, m02;
   } matrix_type;

   typedef struct {
      logic signed [15:0] yaw;
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
      logic               locked;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [14:0] csr_lock_epsilon = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_elem_21 = '0, req_elem_22 = '0, req_elem_20 = '0;
   logic signed [15:0] req_elem_11 = '0, req_elem_01 = '0, req_elem_00 = '0;
   logic signed [15:0] req_elem_02 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;
   logic signed [15:0] rsp_roll_angle;
   logic rsp_gimbal_locked;

   rotation_matrix_to_euler_unit #(.CORDIC_STAGES(STAGES)) uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   matrix_type pending_matrices[$];
   euler_type expected_angles[$];
   logic [14:0] threshold = 15'd1;
   int errors = 0;
   int responses = 0;
   int locked_seen = 0;
   bit drive_on = 1'b0;
   bit req_accepted = 1'b0;

   function automatic longint floor_shift(longint v, int k);
      if (v >= 0) return v >>> k;
      return -((-v - 1) >>> k) - 1;
   endfunction

   function automatic longint angle_of(longint y, longint x);
      longint atan_q24[24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
         524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
         512, 256, 128, 64, 32, 16, 8, 4, 2};
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 26353589;
         end else begin
            x = -y;
            y = t;
            z = -26353589;
         end
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += atan_q24[i];
         end else begin
            x -= ys;
            y += xs;
            z -= atan_q24[i];
         end
      end
      z = floor_shift(z + 1024, 11);
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z;
   endfunction

   function automatic euler_type euler_of(matrix_type m, logic [14:0] eps);
      euler_type e;
      longint s, c, p, r, mag;
      s = -longint'(m.m21);
      if (s > 16384) s = 16384;
      if (s < -16384) s = -16384;
      c = longint'($floor($sqrt(real'(268435456 - s * s))));
      while (c * c > 268435456 - s * s) c--;
      while ((c + 1) * (c + 1) <= 268435456 - s * s) c++;
      p = angle_of(s * 16384, c * 16384);
      if (p > 12868) p = 12868;
      if (p < -12868) p = -12868;
      mag = s < 0 ? -s : s;
      e.pitch = p[14:0];
      e.locked = (16384 - mag) <= longint'(eps);
      if (!e.locked) begin
         e.yaw = 16'(angle_of(longint'(m.m20) * 16384, longint'(m.m22) * 16384));
         r = angle_of(longint'(m.m01) * 16384, longint'(m.m11) * 16384);
      end else begin
         e.yaw = '0;
         r = angle_of(longint'(m.m02) * s, longint'(m.m00) * 16384);
      end
      e.roll = r[15:0];
      return e;
   endfunction

   function automatic logic signed [15:0] random_element();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'sd16384;
         2: return -16'sd16384;
         3: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type m;
      m.m21 = random_element();
      m.m22 = random_element();
      m.m20 = random_element();
      m.m11 = random_element();
      m.m01 = random_element();
      m.m00 = random_element();
      m.m02 = random_element();
      if ($urandom_range(0, 5) == 0)
         m.m21 = 16'($urandom_range(0, 1) ? 16384 - $urandom_range(0, 40)
                                          : -16384 + $urandom_range(0, 40));
      return m;
   endfunction

   int req_gap = 0;
   always @(negedge clock) begin
      if (reset || !drive_on) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_matrices.size() > 0 &&
                   !(req_valid && pending_matrices.size() == 0)) begin
         req_valid <= 1'b1;
         req_elem_21 <= pending_matrices[0].m21;
         req_elem_22 <= pending_matrices[0].m22;
         req_elem_20 <= pending_matrices[0].m20;
         req_elem_11 <= pending_matrices[0].m11;
         req_elem_01 <= pending_matrices[0].m01;
         req_elem_00 <= pending_matrices[0].m00;
         req_elem_02 <= pending_matrices[0].m02;
         req_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_angles.push_back(euler_of(pending_matrices[0], threshold));
         void'(pending_matrices.pop_front());
      end
   end

   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      euler_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_angles.size() == 0) begin
            $error("unexpected response");
            errors++;
         end else begin
            e = expected_angles.pop_front();
            responses++;
            if (e.locked) locked_seen++;
            if (rsp_yaw_angle !== e.yaw) begin
               $error("yaw_angle expected %0d actual %0d", e.yaw, rsp_yaw_angle);
               errors++;
            end
            if (rsp_pitch_angle !== e.pitch) begin
               $error("pitch_angle expected %0d actual %0d", e.pitch, rsp_pitch_angle);
               errors++;
            end
            if (rsp_roll_angle !== e.roll) begin
               $error("roll_angle expected %0d actual %0d", e.roll, rsp_roll_angle);
               errors++;
            end
            if (rsp_gimbal_locked !== e.locked) begin
               $error("gimbal_locked expected %0d actual %0d", e.locked,
                      rsp_gimbal_locked);
               errors++;
            end
         end
      end
   end

   task automatic write_threshold(input logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_lock_epsilon <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_matrices.size() > 0 || req_valid || expected_angles.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic add_matrix(input logic signed [15:0] a, b, c, d, e, f, g);
      matrix_type m;
      m.m21 = a; m.m22 = b; m.m20 = c; m.m11 = d; m.m01 = e; m.m00 = f; m.m02 = g;
      pending_matrices.push_back(m);
   endtask

   initial begin
      logic [14:0] settings[5] = '{15'd0, 15'd16384, 15'd32767, 15'd200, 15'd1};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drive_on = 1'b1;
      add_matrix(0, 16384, 0, 16384, 0, 16384, 0);
      add_matrix(-16384, 0, 0, 0, 0, 16384, 16384);
      add_matrix(16384, 0, 0, 0, 0, 16384, -16384);
      add_matrix(-16383, 0, 0, 0, 0, 16384, 16384);
      add_matrix(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      add_matrix(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
      add_matrix(0, 0, 0, 0, 0, 0, 0);
      add_matrix(-16384, 0, 0, 0, 0, 0, 0);
      add_matrix(0, -16384, 0, -16384, 0, 0, 0);
      add_matrix(0, -16384, 1, -16384, -1, 0, 0);
      add_matrix(0, -16384, -1, -16384, 1, 0, 0);
      add_matrix(11585, 11585, 11585, -11585, -11585, 0, 0);
      add_matrix(-1, 5, -7, -3, 9, -16384, 16384);
      drain();
      foreach (settings[k]) begin
         write_threshold(settings[k]);
         for (int n = 0; n < 290; n++) pending_matrices.push_back(random_matrix());
         drain();
      end
      $display("Checked %0d responses, %0d in gimbal lock, over %0d lock thresholds.",
               responses, locked_seen, 5);
      if (errors == 0)
         $display("rotation_matrix_to_euler_unit verification clean");
      else
         $display("rotation_matrix_to_euler_unit verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("rotation_matrix_to_euler_unit verification failed");
      $finish;
   end

endmodule

`default_nettype wire
